// ===== hdl/occupancy_grid_update_decay_core_macros.svh =====
// ----------------------------------------------------------------------------
// occupancy grid core assertion macros
// shorthand for clocked implications, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_UPDATE_DECAY_CORE_MACROS_SVH
`define OCCUPANCY_GRID_UPDATE_DECAY_CORE_MACROS_SVH

// same-cycle implication
`define OGUD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OGUD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ogud_pkg.sv =====
// ----------------------------------------------------------------------------
// ogud_pkg
// shared types, codes and register reset values of the occupancy grid core
// ----------------------------------------------------------------------------
package ogud_pkg;

  localparam int COORD_W = 16;
  localparam int CPM_W   = 8;
  localparam int INC_W   = 9;
  localparam int FAC_W   = 9;
  localparam int LIK_W   = 8;
  localparam int STAMP_W = 32;

  typedef logic [1:0]                opcode_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [STAMP_W-1:0]        stamp_t;
  typedef logic [7:0]                cell_t;
  typedef logic [15:0]               cell_idx_t;
  typedef logic [LIK_W-1:0]          lik_t;
  typedef logic [7:0]                cfg_idx_t;
  typedef logic [15:0]               cfg_data_t;

  // opcode 2 and the unused code 3 both read a cell
  localparam opcode_t OP_UPDATE = 2'd0;
  localparam opcode_t OP_DECAY  = 2'd1;

  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_OUTSIDE = 3'd1,
    ST_MARKED  = 3'd2,
    ST_DECAYED = 3'd3,
    ST_READ    = 3'd4
  } status_t;

  localparam cfg_idx_t REG_X_MIN        = 8'd0;
  localparam cfg_idx_t REG_Y_MIN        = 8'd1;
  localparam cfg_idx_t REG_X_MAX        = 8'd2;
  localparam cfg_idx_t REG_Y_MAX        = 8'd3;
  localparam cfg_idx_t REG_CELLS_PER_M  = 8'd4;
  localparam cfg_idx_t REG_INCREMENT    = 8'd5;
  localparam cfg_idx_t REG_DECAY_THRESH = 8'd6;
  localparam cfg_idx_t REG_DECAY_SCALE  = 8'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] y_min;
    logic signed [COORD_W-1:0] x_max;
    logic signed [COORD_W-1:0] y_max;
    logic [CPM_W-1:0]          cells_per_meter;
    logic signed [INC_W-1:0]   increment;
    logic [LIK_W-1:0]          decay_threshold;
    logic [FAC_W-1:0]          decay_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    x_min:           16'h8000,
    y_min:           16'h8000,
    x_max:           16'h7FFF,
    y_max:           16'h7FFF,
    cells_per_meter: 8'd50,
    increment:       9'd1,
    decay_threshold: 8'd255,
    decay_scale:     9'd256
  };

endpackage

// ===== hdl/ogud_in_if.sv =====
// ----------------------------------------------------------------------------
// ogud_in_if
// request channel: opcode, point, scan time and addressed cell
// ----------------------------------------------------------------------------
interface ogud_in_if;
  logic               valid;
  logic               ready;
  ogud_pkg::opcode_t  opcode;
  ogud_pkg::coord_t   pos_x;
  ogud_pkg::coord_t   pos_y;
  ogud_pkg::stamp_t   scan_time;
  ogud_pkg::cell_t    cell_x;
  ogud_pkg::cell_t    cell_y;

  modport source (
    output valid, opcode, pos_x, pos_y, scan_time, cell_x, cell_y,
    input  ready
  );
  modport sink (
    input  valid, opcode, pos_x, pos_y, scan_time, cell_x, cell_y,
    output ready
  );
endinterface

// ===== hdl/ogud_out_if.sv =====
// ----------------------------------------------------------------------------
// ogud_out_if
// result channel: status, touched cell and its likelihood
// ----------------------------------------------------------------------------
interface ogud_out_if;
  logic                 valid;
  logic                 ready;
  ogud_pkg::status_t    status;
  ogud_pkg::cell_idx_t  cell_index;
  ogud_pkg::lik_t       cell_value;
  logic                 index_overflow;

  modport source (
    output valid, status, cell_index, cell_value, index_overflow,
    input  ready
  );
  modport sink (
    input  valid, status, cell_index, cell_value, index_overflow,
    output ready
  );
endinterface

// ===== hdl/ogud_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ogud_cfg_if
// register write channel: register index and write data
// ----------------------------------------------------------------------------
interface ogud_cfg_if;
  logic                 valid;
  logic                 ready;
  ogud_pkg::cfg_idx_t   index;
  ogud_pkg::cfg_data_t  data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== hdl/ogud_ram.sv =====
// ----------------------------------------------------------------------------
// ogud_ram
// generic single-write, single-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module ogud_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ogud_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ogud_cfg_regs
// configuration register file, written one beat at a time
// ----------------------------------------------------------------------------
module ogud_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  ogud_cfg_if.sink        cfg_ch,
  output ogud_pkg::cfg_t  cfg_o
);

  ogud_pkg::cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ogud_pkg::CFG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        ogud_pkg::REG_X_MIN:        cfg_r.x_min           <= cfg_ch.data;
        ogud_pkg::REG_Y_MIN:        cfg_r.y_min           <= cfg_ch.data;
        ogud_pkg::REG_X_MAX:        cfg_r.x_max           <= cfg_ch.data;
        ogud_pkg::REG_Y_MAX:        cfg_r.y_max           <= cfg_ch.data;
        ogud_pkg::REG_CELLS_PER_M:  cfg_r.cells_per_meter <= cfg_ch.data[7:0];
        ogud_pkg::REG_INCREMENT:    cfg_r.increment       <= cfg_ch.data[8:0];
        ogud_pkg::REG_DECAY_THRESH: cfg_r.decay_threshold <= cfg_ch.data[7:0];
        ogud_pkg::REG_DECAY_SCALE:  cfg_r.decay_scale     <= cfg_ch.data[8:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== hdl/occupancy_grid_update_decay_core.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_update_decay_core
// occupancy grid of likelihoods with per-cell scan stamps: point hits, decay
// and reads of cells held in two synchronous rams; a hit that is not marked
// writes both back, a decay writes the likelihood back and a read writes nothing
//  channel  | dir | payload                                        | handshake
//  in_ch    | in  | opcode pos_x pos_y scan_time cell_x cell_y      | valid/ready
//  out_ch   | out | status cell_index cell_value index_overflow     | valid/ready
//  cfg_ch   | in  | index data                                      | valid/ready
//
//  one beat at a time: a beat that touches a cell passes accept, address and
//  ram read, then modify and write back; a dropped point or an off-grid cell
//  ends after the address step; the single ram read-modify-write keeps beats apart.
//  after reset both rams are cleared, one entry a cycle over all
//  GRID_DIM*GRID_DIM entries with in_ch.ready low; cfg_ch is always ready.
//  a stalled out_ch holds the finished beat; the core waits on it only when
//  the next result is done.
// ----------------------------------------------------------------------------
`include "occupancy_grid_update_decay_core_macros.svh"

module occupancy_grid_update_decay_core #(
  parameter int GRID_DIM        = 256,
  parameter int COORD_FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  ogud_in_if.sink     in_ch,
  ogud_out_if.source  out_ch,
  ogud_cfg_if.sink    cfg_ch
);

  localparam int DEPTH  = GRID_DIM * GRID_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PROD_W = ogud_pkg::COORD_W + 1 + ogud_pkg::CPM_W;
  localparam logic [31:0]       GRID_LIM  = 32'(GRID_DIM);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_MOD
  } state_t;

  ogud_pkg::cfg_t cfg;

  ogud_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  state_t                state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_cnt_r;

  ogud_pkg::opcode_t     op_r;
  ogud_pkg::stamp_t      time_r;
  ogud_pkg::cell_t       cx_r, cy_r;
  logic [PROD_W-1:0]     prod_x_r, prod_y_r, prod_x_nxt, prod_y_nxt;
  logic                  outside_r, outside_nxt;
  ogud_pkg::cell_idx_t   idx_r;
  logic [ADDR_W-1:0]     addr_r;

  logic                  out_valid_r;
  ogud_pkg::status_t     out_status_r;
  ogud_pkg::cell_idx_t   out_idx_r;
  ogud_pkg::lik_t        out_val_r;
  logic                  out_ovf_r;

  logic                  in_ready, in_acc, load_out, commit, byp_load;
  logic signed [16:0]    dx_s, dy_s;

  logic [31:0]           row_sel, col_sel, idx_full;
  logic                  is_upd, is_dec, ovf, bypass, byp_ovf;
  ogud_pkg::status_t     byp_status;

  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr, wr_addr;
  ogud_pkg::lik_t        lk_rd, lk_wdata;
  ogud_pkg::stamp_t      st_rd, st_wdata;
  logic                  lk_we, st_we;

  logic                  marked;
  logic signed [10:0]    sum_s;
  ogud_pkg::lik_t        upd_val, dec_val, mod_val;
  logic [16:0]           dec_prod;
  ogud_pkg::status_t     mod_status;
  logic                  mod_lk_wr, mod_st_wr;

  // accept: bounds test and scaling multiply, registered
  assign in_ready    = (state_r == S_IDLE);
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;

  assign dx_s = 17'(in_ch.pos_x) - 17'(cfg.x_min);
  assign dy_s = 17'(in_ch.pos_y) - 17'(cfg.y_min);
  assign prod_x_nxt = PROD_W'(dx_s[16:0]) * PROD_W'(cfg.cells_per_meter);
  assign prod_y_nxt = PROD_W'(dy_s[16:0]) * PROD_W'(cfg.cells_per_meter);
  assign outside_nxt = (in_ch.pos_x < cfg.x_min) || (in_ch.pos_x > cfg.x_max) ||
                       (in_ch.pos_y < cfg.y_min) || (in_ch.pos_y > cfg.y_max);

  // address stage
  assign is_upd  = (op_r == ogud_pkg::OP_UPDATE);
  assign is_dec  = (op_r == ogud_pkg::OP_DECAY);
  assign row_sel = is_upd ? 32'(prod_x_r >> COORD_FRAC_BITS) : 32'(cx_r);
  assign col_sel = is_upd ? 32'(prod_y_r >> COORD_FRAC_BITS) : 32'(cy_r);
  assign ovf      = (row_sel >= GRID_LIM) || (col_sel >= GRID_LIM);
  assign idx_full = row_sel * GRID_LIM + col_sel;
  assign bypass   = (is_upd && outside_r) || ovf;
  assign byp_ovf  = !(is_upd && outside_r) && ovf;

  always_comb begin
    priority if (is_upd) begin
      byp_status = ogud_pkg::ST_OUTSIDE;
    end else if (is_dec) begin
      byp_status = ogud_pkg::ST_DECAYED;
    end else begin
      byp_status = ogud_pkg::ST_READ;
    end
  end

  assign rd_en   = (state_r == S_ADDR) && !bypass;
  assign rd_addr = idx_full[ADDR_W-1:0];

  // modify stage
  assign marked   = (st_rd >= time_r);
  assign sum_s    = $signed({3'b000, lk_rd}) + 11'(cfg.increment);
  assign dec_prod = 17'(lk_rd) * 17'(cfg.decay_scale);

  always_comb begin
    if (sum_s[10]) begin
      upd_val = '0;
    end else if (sum_s[9:8] != 2'b00) begin
      upd_val = 8'hFF;
    end else begin
      upd_val = sum_s[7:0];
    end
    // at or above threshold pins to it, else scale by the q1.8 factor
    if (lk_rd >= cfg.decay_threshold) begin
      dec_val = cfg.decay_threshold;
    end else if (dec_prod[16]) begin
      dec_val = 8'hFF;
    end else begin
      dec_val = dec_prod[15:8];
    end
  end

  always_comb begin
    priority if (is_upd && marked) begin
      mod_status = ogud_pkg::ST_MARKED;
      mod_val    = lk_rd;
      mod_lk_wr  = 1'b0;
      mod_st_wr  = 1'b0;
    end else if (is_upd) begin
      mod_status = ogud_pkg::ST_UPDATED;
      mod_val    = upd_val;
      mod_lk_wr  = 1'b1;
      mod_st_wr  = 1'b1;
    end else if (is_dec) begin
      mod_status = ogud_pkg::ST_DECAYED;
      mod_val    = dec_val;
      mod_lk_wr  = 1'b1;
      mod_st_wr  = 1'b0;
    end else begin
      mod_status = ogud_pkg::ST_READ;
      mod_val    = lk_rd;
      mod_lk_wr  = 1'b0;
      mod_st_wr  = 1'b0;
    end
  end

  assign load_out = !out_valid_r || out_ch.ready;
  assign commit   = (state_r == S_MOD) && load_out;
  assign byp_load = (state_r == S_ADDR) && bypass && load_out;

  // ram write port: clearing sweep or write-back on commit
  assign wr_addr  = (state_r == S_CLEAR) ? clr_cnt_r : addr_r;
  assign lk_we    = (state_r == S_CLEAR) || (commit && mod_lk_wr);
  assign st_we    = (state_r == S_CLEAR) || (commit && mod_st_wr);
  assign lk_wdata = (state_r == S_CLEAR) ? '0 : mod_val;
  assign st_wdata = (state_r == S_CLEAR) ? '0 : time_r;

  ogud_ram #(
    .WIDTH (ogud_pkg::LIK_W),
    .DEPTH (DEPTH)
  ) u_lk_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (wr_addr),
    .wdata (lk_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (lk_rd)
  );

  ogud_ram #(
    .WIDTH (ogud_pkg::STAMP_W),
    .DEPTH (DEPTH)
  ) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (wr_addr),
    .wdata (st_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (st_rd)
  );

  always_comb begin
    unique case (state_r)
      S_CLEAR: state_nxt = (clr_cnt_r == LAST_ADDR) ? S_IDLE : S_CLEAR;
      S_IDLE:  state_nxt = in_acc ? S_ADDR : S_IDLE;
      S_ADDR: begin
        if (bypass) begin
          state_nxt = load_out ? S_IDLE : S_ADDR;
        end else begin
          state_nxt = S_MOD;
        end
      end
      S_MOD:   state_nxt = load_out ? S_IDLE : S_MOD;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (in_acc) begin
        op_r      <= in_ch.opcode;
        time_r    <= in_ch.scan_time;
        cx_r      <= in_ch.cell_x;
        cy_r      <= in_ch.cell_y;
        prod_x_r  <= prod_x_nxt;
        prod_y_r  <= prod_y_nxt;
        outside_r <= outside_nxt;
      end
      if (rd_en) begin
        idx_r  <= idx_full[15:0];
        addr_r <= rd_addr;
      end
      if (byp_load) begin
        out_valid_r  <= 1'b1;
        out_status_r <= byp_status;
        out_idx_r    <= '0;
        out_val_r    <= '0;
        out_ovf_r    <= byp_ovf;
      end else if (commit) begin
        out_valid_r  <= 1'b1;
        out_status_r <= mod_status;
        out_idx_r    <= idx_r;
        out_val_r    <= mod_val;
        out_ovf_r    <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_status_r;
  assign out_ch.cell_index     = out_idx_r;
  assign out_ch.cell_value     = out_val_r;
  assign out_ch.index_overflow = out_ovf_r;

  `OGUD_ASSERT_IMP(a_lk_wr_clear_or_commit, lk_we, (state_r == S_CLEAR) || commit, "likelihood write outside clear or commit")
  `OGUD_ASSERT_IMP(a_st_wr_with_lk_wr, st_we, lk_we && ((state_r == S_CLEAR) || is_upd), "stamp write without matching likelihood write")
  `OGUD_ASSERT_IMP(a_updated_in_grid, out_valid_r && (out_status_r == ogud_pkg::ST_UPDATED), !out_ovf_r, "updated cell flagged off grid")
  `OGUD_ASSERT_NXT(a_accept_to_addr, in_acc, state_r == S_ADDR, "accepted beat did not enter address stage")
  `OGUD_ASSERT_IMP(a_no_accept_busy, in_acc, !rd_en && !lk_we, "beat accepted while ram access in flight")

endmodule

// ===== dv/tb_occupancy_grid_update_decay_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_occupancy_grid_update_decay_core
// self-checking bench for the occupancy grid core: a cycle-free model of the
// likelihood and stamp grids predicts every result beat, which is compared
// field by field in arrival order under random source gaps and sink stalls
// ----------------------------------------------------------------------------
module tb_occupancy_grid_update_decay_core;

  localparam int GRID_DIM      = 256;
  localparam int FRAC_BITS     = 8;
  localparam int CELL_COUNT    = GRID_DIM * GRID_DIM;
  localparam int LIK_MAX       = 255;
  localparam int MAX_IDLE      = 14;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 16;
  localparam int HIT_ROWS      = 25;
  localparam int PHASE_ITEMS   = 235;
  localparam int MAX_PRINTS    = 100;

  localparam ogud_pkg::opcode_t OP_READ  = 2'd2;
  // the spare code decodes as a read
  localparam ogud_pkg::opcode_t OP_SPARE = 2'd3;

  typedef struct {
    ogud_pkg::opcode_t opcode;
    ogud_pkg::coord_t  pos_x;
    ogud_pkg::coord_t  pos_y;
    ogud_pkg::stamp_t  scan_time;
    ogud_pkg::cell_t   cell_x;
    ogud_pkg::cell_t   cell_y;
  } grid_req_t;

  typedef struct {
    ogud_pkg::status_t   status;
    ogud_pkg::cell_idx_t cell_index;
    ogud_pkg::lik_t      cell_value;
    logic                index_overflow;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ogud_in_if  in_ch ();
  ogud_out_if out_ch ();
  ogud_cfg_if cfg_ch ();

  occupancy_grid_update_decay_core #(
    .GRID_DIM        (GRID_DIM),
    .COORD_FRAC_BITS (FRAC_BITS)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ogud_pkg::cfg_t             grid_cfg = ogud_pkg::CFG_RESET;
  bit [ogud_pkg::LIK_W-1:0]   lik_model   [CELL_COUNT];
  bit [ogud_pkg::STAMP_W-1:0] stamp_model [CELL_COUNT];
  cell_result_t               cell_result_q [$];
  int                         error_count = 0;
  bit                         pacing;
  bit                         hold_req;
  ogud_pkg::stamp_t           scan_now;

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    if (error_count < MAX_PRINTS)
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // grid model: one call per accepted beat; a hit updates both stores, a decay only the likelihood
  function automatic cell_result_t apply_grid_op(grid_req_t r);
    cell_result_t res;
    int px, py, x_lo, y_lo, row, col, idx, v;
    res = '{status: ogud_pkg::ST_OUTSIDE, cell_index: '0, cell_value: '0,
            index_overflow: 1'b0};
    if (r.opcode == ogud_pkg::OP_UPDATE) begin
      px   = int'(r.pos_x);
      py   = int'(r.pos_y);
      x_lo = int'($signed(grid_cfg.x_min));
      y_lo = int'($signed(grid_cfg.y_min));
      if (px < x_lo || px > int'($signed(grid_cfg.x_max)) ||
          py < y_lo || py > int'($signed(grid_cfg.y_max)))
        return res;
      row = ((px - x_lo) * int'(grid_cfg.cells_per_meter)) >>> FRAC_BITS;
      col = ((py - y_lo) * int'(grid_cfg.cells_per_meter)) >>> FRAC_BITS;
      if (row >= GRID_DIM || col >= GRID_DIM) begin
        res.index_overflow = 1'b1;
        return res;
      end
      idx = row * GRID_DIM + col;
      res.cell_index = ogud_pkg::cell_idx_t'(idx);
      if (stamp_model[idx] >= r.scan_time) begin
        res.status     = ogud_pkg::ST_MARKED;
        res.cell_value = lik_model[idx];
        return res;
      end
      v = int'(lik_model[idx]) + int'($signed(grid_cfg.increment));
      if (v > LIK_MAX) v = LIK_MAX;
      if (v < 0) v = 0;
      lik_model[idx]   = ogud_pkg::lik_t'(v);
      stamp_model[idx] = r.scan_time;
      res.status     = ogud_pkg::ST_UPDATED;
      res.cell_value = ogud_pkg::lik_t'(v);
    end else begin
      res.status = (r.opcode == ogud_pkg::OP_DECAY) ? ogud_pkg::ST_DECAYED
                                                    : ogud_pkg::ST_READ;
      row = int'(r.cell_x);
      col = int'(r.cell_y);
      if (row >= GRID_DIM || col >= GRID_DIM) begin
        res.index_overflow = 1'b1;
        return res;
      end
      idx = row * GRID_DIM + col;
      v   = int'(lik_model[idx]);
      if (r.opcode == ogud_pkg::OP_DECAY) begin
        if (v >= int'(grid_cfg.decay_threshold)) begin
          v = int'(grid_cfg.decay_threshold);
        end else begin
          v = (v * int'(grid_cfg.decay_scale)) >>> 8;
          if (v > LIK_MAX) v = LIK_MAX;
        end
        lik_model[idx] = ogud_pkg::lik_t'(v);
      end
      res.cell_index = ogud_pkg::cell_idx_t'(idx);
      res.cell_value = ogud_pkg::lik_t'(v);
    end
    return res;
  endfunction

  function automatic grid_req_t point_req(int x, int y, ogud_pkg::stamp_t t);
    grid_req_t r;
    r = '{opcode: ogud_pkg::OP_UPDATE, pos_x: ogud_pkg::coord_t'(x),
          pos_y: ogud_pkg::coord_t'(y), scan_time: t, cell_x: '0, cell_y: '0};
    return r;
  endfunction

  function automatic grid_req_t cell_req(ogud_pkg::opcode_t op, int cx, int cy);
    grid_req_t r;
    r = '{opcode: op, pos_x: '0, pos_y: '0, scan_time: '0,
          cell_x: ogud_pkg::cell_t'(cx), cell_y: ogud_pkg::cell_t'(cy)};
    return r;
  endfunction

  // valid stays high across back-to-back beats
  task automatic send_item(grid_req_t r);
    int gap;
    cell_result_t res;
    gap = pacing ? int'($urandom_range(0, MAX_IDLE)) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= r.opcode;
    in_ch.pos_x     <= r.pos_x;
    in_ch.pos_y     <= r.pos_y;
    in_ch.scan_time <= r.scan_time;
    in_ch.cell_x    <= r.cell_x;
    in_ch.cell_y    <= r.cell_y;
    do @(posedge clk); while (!in_ch.ready);
    res = apply_grid_op(r);
    cell_result_q.insert(cell_result_q.size(), res);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (cell_result_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(ogud_pkg::cfg_idx_t idx, ogud_pkg::cfg_data_t data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      ogud_pkg::REG_X_MIN:        grid_cfg.x_min = data;
      ogud_pkg::REG_Y_MIN:        grid_cfg.y_min = data;
      ogud_pkg::REG_X_MAX:        grid_cfg.x_max = data;
      ogud_pkg::REG_Y_MAX:        grid_cfg.y_max = data;
      ogud_pkg::REG_CELLS_PER_M:  grid_cfg.cells_per_meter = data[ogud_pkg::CPM_W-1:0];
      ogud_pkg::REG_INCREMENT:    grid_cfg.increment       = data[ogud_pkg::INC_W-1:0];
      ogud_pkg::REG_DECAY_THRESH: grid_cfg.decay_threshold = data[ogud_pkg::LIK_W-1:0];
      ogud_pkg::REG_DECAY_SCALE:  grid_cfg.decay_scale     = data[ogud_pkg::FAC_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_config(ogud_pkg::cfg_t c);
    write_reg(ogud_pkg::REG_X_MIN,        ogud_pkg::cfg_data_t'(c.x_min));
    write_reg(ogud_pkg::REG_Y_MIN,        ogud_pkg::cfg_data_t'(c.y_min));
    write_reg(ogud_pkg::REG_X_MAX,        ogud_pkg::cfg_data_t'(c.x_max));
    write_reg(ogud_pkg::REG_Y_MAX,        ogud_pkg::cfg_data_t'(c.y_max));
    write_reg(ogud_pkg::REG_CELLS_PER_M,  ogud_pkg::cfg_data_t'(c.cells_per_meter));
    write_reg(ogud_pkg::REG_INCREMENT,    ogud_pkg::cfg_data_t'(c.increment));
    write_reg(ogud_pkg::REG_DECAY_THRESH, ogud_pkg::cfg_data_t'(c.decay_threshold));
    write_reg(ogud_pkg::REG_DECAY_SCALE,  ogud_pkg::cfg_data_t'(c.decay_scale));
  endtask

  function automatic ogud_pkg::cfg_t draw_config();
    ogud_pkg::cfg_t c;
    int lo_x, lo_y;
    lo_x = int'($urandom_range(0, 49151)) - 32768;
    lo_y = int'($urandom_range(0, 49151)) - 32768;
    c.x_min           = ogud_pkg::coord_t'(lo_x);
    c.y_min           = ogud_pkg::coord_t'(lo_y);
    c.x_max           = ogud_pkg::coord_t'(lo_x + int'($urandom_range(256, 16384)));
    c.y_max           = ogud_pkg::coord_t'(lo_y + int'($urandom_range(256, 16384)));
    c.cells_per_meter = 8'($urandom_range(1, 255));
    c.increment       = 9'(int'($urandom_range(0, 510)) - 255);
    c.decay_threshold = 8'($urandom_range(0, 255));
    c.decay_scale     = 9'($urandom_range(0, 256));
    return c;
  endfunction

  // mostly in-box hits on a small patch of cells so stamps, clamps and decays
  // interact; the rest is noise points over the whole field range and decays and reads, mostly on the patch
  function automatic grid_req_t draw_request();
    grid_req_t r;
    int kind, span_x, span_y, reach;
    r.opcode    = ogud_pkg::OP_UPDATE;
    r.pos_x     = ogud_pkg::coord_t'($urandom);
    r.pos_y     = ogud_pkg::coord_t'($urandom);
    r.scan_time = scan_now;
    r.cell_x    = ogud_pkg::cell_t'($urandom);
    r.cell_y    = ogud_pkg::cell_t'($urandom);
    kind  = int'($urandom_range(0, 99));
    reach = (HIT_ROWS * 256) / int'(grid_cfg.cells_per_meter) - 1;
    if (kind < 55) begin
      span_x = int'($signed(grid_cfg.x_max)) - int'($signed(grid_cfg.x_min));
      span_y = int'($signed(grid_cfg.y_max)) - int'($signed(grid_cfg.y_min));
      if (span_x > reach) span_x = reach;
      if (span_y > reach) span_y = reach;
      if (span_x < 0) span_x = 0;
      if (span_y < 0) span_y = 0;
      r.pos_x = ogud_pkg::coord_t'(int'($signed(grid_cfg.x_min)) +
                                   int'($urandom_range(0, span_x)));
      r.pos_y = ogud_pkg::coord_t'(int'($signed(grid_cfg.y_min)) +
                                   int'($urandom_range(0, span_y)));
      if ($urandom_range(0, 6) == 0) r.scan_time = scan_now - $urandom_range(0, 3);
    end else if (kind < 65) begin
      if ($urandom_range(0, 7) == 0) r.scan_time = $urandom;
    end else begin
      r.opcode = ogud_pkg::OP_DECAY;
      if (kind >= 85) r.opcode = ($urandom_range(0, 3) == 0) ? OP_SPARE : OP_READ;
      if ($urandom_range(0, 4) != 0) begin
        r.cell_x = ogud_pkg::cell_t'($urandom_range(0, HIT_ROWS - 1));
        r.cell_y = ogud_pkg::cell_t'($urandom_range(0, HIT_ROWS - 1));
      end
    end
    return r;
  endfunction

  task automatic run_traffic(int n_items);
    repeat (n_items) begin
      if ($urandom_range(0, 49) == 0) pacing = ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 7) == 0) scan_now++;
      send_item(draw_request());
    end
    drain_results();
  endtask

  // reset register values: the box origin maps to cell 0, the point 0,0 far off the grid
  task automatic test_reset_state();
    send_item(cell_req(OP_READ, 0, 0));
    send_item(point_req(-32768, -32768, 1));
    send_item(point_req(0, 0, 1));
    send_item(point_req(-32768, -32768, 1));
    // a zero scan time never beats the cleared stamp
    send_item(point_req(-32762, -32762, 0));
    drain_results();
  endtask

  task automatic test_bounds_and_hits();
    ogud_pkg::cfg_t c;
    c = '{x_min: -16'sd256, y_min: -16'sd256, x_max: 16'sd255, y_max: 16'sd255,
          cells_per_meter: 8'd128, increment: 9'sd255, decay_threshold: 8'd200,
          decay_scale: 9'd128};
    program_config(c);
    send_item(point_req(-257, 0, 2));
    send_item(point_req(256, 0, 2));
    send_item(point_req(0, -257, 2));
    send_item(point_req(0, 256, 2));
    send_item(point_req(255, 255, 2));
    send_item(point_req(-256, -256, 2));
    drain_results();
  endtask

  task automatic test_decay_and_read();
    send_item(cell_req(ogud_pkg::OP_DECAY, 255, 255));
    send_item(cell_req(ogud_pkg::OP_DECAY, 255, 255));
    drain_results();
    write_reg(ogud_pkg::REG_DECAY_THRESH, ogud_pkg::cfg_data_t'(255));
    send_item(cell_req(ogud_pkg::OP_DECAY, 255, 255));
    send_item(cell_req(OP_SPARE, 255, 255));
    drain_results();
  endtask

  task automatic test_clamp_and_stamps();
    write_reg(ogud_pkg::REG_INCREMENT, ogud_pkg::cfg_data_t'(-255));
    send_item(point_req(255, 255, 3));
    send_item(point_req(255, 255, 32'hFFFF_FFFF));
    send_item(point_req(255, 255, 32'hFFFF_FFFF));
    drain_results();
    write_reg(ogud_pkg::REG_DECAY_SCALE, ogud_pkg::cfg_data_t'(256));
    write_reg(ogud_pkg::REG_CELLS_PER_M, ogud_pkg::cfg_data_t'(255));
    send_item(point_req(255, 255, 4));
    send_item(point_req(-256, -256, 5));
    drain_results();
  endtask

  // lower bound above upper bound drops every point
  task automatic test_inverted_box();
    write_reg(ogud_pkg::REG_X_MIN, ogud_pkg::cfg_data_t'(100));
    write_reg(ogud_pkg::REG_X_MAX, ogud_pkg::cfg_data_t'(-100));
    send_item(point_req(0, 0, 6));
    send_item(point_req(100, 0, 6));
    drain_results();
  endtask

  // sink holds off while the source keeps offering, so the core backs up
  task automatic test_backpressure();
    program_config(draw_config());
    pacing   = 1'b0;
    hold_req = 1'b1;
    repeat (12) send_item(draw_request());
    drain_results();
    pacing = 1'b1;
  endtask

  task automatic test_random_traffic();
    ogud_pkg::cfg_t c;
    c = draw_config();
    c.increment = 9'($urandom_range(1, 40));
    program_config(c);
    run_traffic(PHASE_ITEMS);
    // whole coordinate range at one cell per meter, widest limits
    c = '{x_min: -16'sd32768, y_min: -16'sd32768, x_max: 16'sd32767, y_max: 16'sd32767,
          cells_per_meter: 8'd1, increment: 9'sd255, decay_threshold: 8'd255,
          decay_scale: 9'd256};
    program_config(c);
    run_traffic(PHASE_ITEMS);
    c = draw_config();
    c.cells_per_meter = 8'd255;
    c.increment       = -9'sd255;
    c.decay_threshold = 8'd0;
    c.decay_scale     = 9'd0;
    program_config(c);
    run_traffic(PHASE_ITEMS);
    repeat (3) begin
      program_config(draw_config());
      run_traffic(PHASE_ITEMS);
    end
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = pacing ? int'($urandom_range(0, MAX_IDLE)) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin : result_check
    cell_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (cell_result_q.size() == 0) begin
        flag_mismatch("beat with nothing pending, status", out_ch.status, 0);
      end else begin
        want = cell_result_q.pop_front();
        if (out_ch.status !== want.status)
          flag_mismatch("status", out_ch.status, want.status);
        if (out_ch.cell_index !== want.cell_index)
          flag_mismatch("cell_index", out_ch.cell_index, want.cell_index);
        if (out_ch.cell_value !== want.cell_value)
          flag_mismatch("cell_value", out_ch.cell_value, want.cell_value);
        if (out_ch.index_overflow !== want.index_overflow)
          flag_mismatch("index_overflow", out_ch.index_overflow, want.index_overflow);
      end
    end
  end

  initial begin : watchdog
    #(3_000_000);
    $display("occupancy_grid_update_decay_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.opcode    <= ogud_pkg::OP_UPDATE;
    in_ch.pos_x     <= '0;
    in_ch.pos_y     <= '0;
    in_ch.scan_time <= '0;
    in_ch.cell_x    <= '0;
    in_ch.cell_y    <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= ogud_pkg::REG_X_MIN;
    cfg_ch.data     <= '0;
    pacing   = 1'b1;
    hold_req = 1'b0;
    scan_now = 16;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_bounds_and_hits();
    test_decay_and_read();
    test_clamp_and_stamps();
    test_inverted_box();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0 && cell_result_q.size() == 0)
      $display("occupancy_grid_update_decay_core regression: pass");
    else
      $display("occupancy_grid_update_decay_core regression: fail");
    $finish;
  end

endmodule
